[src/n2a_pkg.sv]
// ----------------------------------------------------------------------------
// n2a_pkg: shared types and constants of the number to ASCII formatter
// Holds the digit chain geometry, the chain control bundle and the
// character encoding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package n2a_pkg;

    // Width of the binary input value.
    localparam int VALUE_W     = 64;
    // Decimal digits needed for the largest 64-bit value.
    localparam int NUM_DIGITS  = 20;
    // Hex digits in a 64-bit value.
    localparam int HEX_DIGITS  = VALUE_W / 4;
    // Width of one emitted ASCII code.
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_X      = 7'h78;
    // Offset that maps nibble values 10..15 onto 'a'..'f'.
    localparam logic [CHAR_W-1:0] ASCII_HEXOFS = 7'h57;

    typedef logic [3:0] n2a_digit_t;

    // Control bundle that drives every cell of the digit chain.
    typedef struct packed {
        logic load;    // load all cells in parallel
        logic dabble;  // one add-3 and shift step of binary to BCD
        logic shift;   // move each digit one cell toward the top
    } n2a_chain_ctl_t;

    // ASCII code of one digit 0..15.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input n2a_digit_t d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-4){1'b0}}, d};
        if (d > 4'd9) begin
            return d_ext + ASCII_HEXOFS;
        end
        return d_ext + ASCII_ZERO;
    endfunction

endpackage

`default_nettype wire

[src/n2a_digit_cell.sv]
// ----------------------------------------------------------------------------
// n2a_digit_cell: one four-bit digit cell of the conversion chain
// Performs one double-dabble step (add 3 when five or more, then shift in
// a bit from the lower neighbor), or takes the lower neighbor's whole digit.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_digit_cell (
    input  wire logic                    clk,
    input  wire n2a_pkg::n2a_chain_ctl_t ctl,
    input  wire n2a_pkg::n2a_digit_t     load_digit,
    input  wire logic                    bit_in,
    input  wire n2a_pkg::n2a_digit_t     digit_in,
    output logic                         bit_out,
    output n2a_pkg::n2a_digit_t          digit_out
);
    import n2a_pkg::*;

    n2a_digit_t digit_reg;
    n2a_digit_t digit_next;
    n2a_digit_t adj;

    // Add-3 correction so the following shift doubles the digit in BCD.
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    assign bit_out   = adj[3];
    assign digit_out = digit_reg;

    // Next digit value.
    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.load) begin
            digit_next = load_digit;
        end else if (ctl.dabble) begin
            digit_next = {adj[2:0], bit_in};
        end else if (ctl.shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

[src/n2a_digit_chain.sv]
// ----------------------------------------------------------------------------
// n2a_digit_chain: row of digit cells
// Cell 0 is the least significant digit; data moves toward the top cell.
// ----------------------------------------------------------------------------
`default_nettype none

module n2a_digit_chain (
    input  wire logic                                      clk,
    input  wire n2a_pkg::n2a_chain_ctl_t                   ctl,
    input  wire n2a_pkg::n2a_digit_t [n2a_pkg::NUM_DIGITS-1:0] load_digits,
    input  wire logic                                      bit_in,
    output n2a_pkg::n2a_digit_t                            top_digit
);
    import n2a_pkg::*;

    logic       [NUM_DIGITS:0] bit_link;
    n2a_digit_t [NUM_DIGITS:0] digit_link;

    // The bottom cell takes the next binary bit, and a zero digit on a shift.
    assign bit_link[0]   = bit_in;
    assign digit_link[0] = '0;

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        n2a_digit_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .load_digit (load_digits[i]),
            .bit_in     (bit_link[i]),
            .digit_in   (digit_link[i]),
            .bit_out    (bit_link[i+1]),
            .digit_out  (digit_link[i+1])
        );
    end

    // The carry out of the top cell is always zero for a 64-bit value.
    assign top_digit = (bit_link[NUM_DIGITS] == 1'b0) ? digit_link[NUM_DIGITS]
                                                      : digit_link[NUM_DIGITS];

endmodule

`default_nettype wire

[src/number_to_ascii_formatter.sv]
// ----------------------------------------------------------------------------
// number_to_ascii_formatter: 64-bit value to ASCII text
// Emits a value as decimal digits without leading zeros, or as "0x" and
// sixteen lowercase hex digits, one character per output transaction.
// ----------------------------------------------------------------------------
// One value is handled at a time; in_ready is high only while the block is
// free. Decimal mode runs a double-dabble step for each of the 64 value bits
// through a row of twenty BCD digit cells, then shifts the leading zero
// digits away, keeping at least one, then shifts out one digit per emitted
// character. Hex mode loads the nibbles straight into the cells and emits
// its 18 characters from there. The final character of each value carries
// last_char. A finished character waits in the output register, so the
// sink may stall at any time.
`default_nettype none

module number_to_ascii_formatter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          mode,
    input  wire logic [n2a_pkg::VALUE_W-1:0]   value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [n2a_pkg::CHAR_W-1:0]    char_code,
    output logic                               last_char
);
    import n2a_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Prefix position: 0 emits '0', 1 emits 'x', PFX_DONE means digits.
    localparam logic [1:0] PFX_ZERO = 2'd0;
    localparam logic [1:0] PFX_X    = 2'd1;
    localparam logic [1:0] PFX_DONE = 2'd2;

    localparam int CNT_W = $clog2(VALUE_W);
    localparam int REM_W = $clog2(NUM_DIGITS + 1);

    state_t                   state_reg, state_next;
    logic [VALUE_W-1:0]       bin_reg, bin_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [1:0]               pfx_reg, pfx_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]        char_reg, char_next;
    logic                     last_reg, last_next;

    n2a_chain_ctl_t                ctl;
    n2a_digit_t [NUM_DIGITS-1:0]   load_digits;
    n2a_digit_t                    top_digit;
    logic                          slot_free;
    logic                          in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // Parallel load: hex nibbles fill the top cells, decimal starts cleared.
    always_comb
    begin
        load_digits = '0;
        if (mode) begin
            for (int i = 0; i < HEX_DIGITS; i++) begin
                load_digits[NUM_DIGITS-HEX_DIGITS+i] = value[4*i +: 4];
            end
        end
    end

    n2a_digit_chain u_chain (
        .clk         (clk),
        .ctl         (ctl),
        .load_digits (load_digits),
        .bit_in      (bin_reg[VALUE_W-1]),
        .top_digit   (top_digit)
    );

    // Sequencer and output register next values.
    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        pfx_next       = pfx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ctl            = '0;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    ctl.load = 1'b1;
                    bin_next = value;
                    cnt_next = '0;
                    if (mode) begin
                        rem_next   = REM_W'(HEX_DIGITS);
                        pfx_next   = PFX_ZERO;
                        state_next = ST_EMIT;
                    end else begin
                        rem_next   = REM_W'(NUM_DIGITS);
                        pfx_next   = PFX_DONE;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                ctl.dabble = 1'b1;
                bin_next   = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && rem_reg > REM_W'(1)) begin
                    ctl.shift = 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    if (pfx_reg == PFX_ZERO) begin
                        char_next = ASCII_ZERO;
                        pfx_next  = PFX_X;
                    end else if (pfx_reg == PFX_X) begin
                        char_next = ASCII_X;
                        pfx_next  = PFX_DONE;
                    end else begin
                        ctl.shift = 1'b1;
                        char_next = digit_to_ascii(top_digit);
                        rem_next  = rem_reg - 1'b1;
                        if (rem_reg == REM_W'(1)) begin
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        pfx_reg  <= pfx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

[sim/tb_number_to_ascii_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_number_to_ascii_formatter: self-checking bench of the ASCII formatter
// A queue of numbers feeds a valid/ready driver. A clocked monitor predicts
// the decimal or hex text of every accepted number and checks each output
// character, in order, against that prediction. Both sides stall at random.
// ----------------------------------------------------------------------------

module tb_number_to_ascii_formatter;

    import n2a_pkg::*;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // Percentage of cycles in which a side holds back.
    localparam int IDLE_PCT   = 29;
    // Quiet cycles after the last expected character.
    localparam int DRAIN_CYC  = 120;
    localparam int MAX_REPORT = 10;
    localparam int NUM_RANDOM = 260;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
    } number_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               mode      = MODE_DEC;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  char_code;
    logic               last_char;

    number_item_t pending_numbers[$];
    text_char_t   expected_chars[$];

    int  num_items    = 0;
    int  num_accepted = 0;
    int  num_errors   = 0;
    logic in_taken    = 1'b0;
    logic calm;

    // A stretch of numbers in the middle of the run sees no stalls at all.
    assign calm = (num_accepted >= 100) && (num_accepted < 150);

    number_to_ascii_formatter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

    always #6 clk = ~clk;

    // Count an error; only the first few are printed.
    task automatic report_error(input string msg);
        num_errors++;
        if (num_errors <= MAX_REPORT)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // Append the characters that one number is expected to produce.
    task automatic predict_chars(input logic m, input logic [VALUE_W-1:0] v);
        logic [3:0]         digits [NUM_DIGITS];
        logic [VALUE_W-1:0] rest;
        logic [3:0]         nib;
        int                 n;
        if (m == MODE_HEX)
        begin
            expected_chars.push_back('{ASCII_ZERO, 1'b0});
            expected_chars.push_back('{ASCII_X, 1'b0});
            for (int sh = VALUE_W - 4; sh >= 0; sh -= 4)
            begin
                nib = v[sh +: 4];
                expected_chars.push_back('{(nib > 4'd9) ? {3'b000, nib} + ASCII_HEXOFS
                                                        : {3'b000, nib} + ASCII_ZERO,
                                           sh == 0});
            end
        end
        else if (v == '0)
        begin
            // Zero still prints one digit.
            expected_chars.push_back('{ASCII_ZERO, 1'b1});
        end
        else
        begin
            rest = v;
            n = 0;
            while (rest != '0)
            begin
                digits[n] = 4'(rest % 10);
                rest = rest / 10;
                n++;
            end
            for (int j = n - 1; j >= 0; j--)
            begin
                expected_chars.push_back('{{3'b000, digits[j]} + ASCII_ZERO, j == 0});
            end
        end
    endtask

    // Input driver: a new transaction is offered only when the slot is free.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_numbers.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    mode     <= pending_numbers[0].mode;
                    value    <= pending_numbers[0].value;
                    pending_numbers.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output sink: random back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_chars(mode, value);
                num_accepted <= num_accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_error($sformatf("unexpected char code=%02h last=%0b",
                                           char_code, last_char));
                end
                else
                begin
                    if (char_code !== expected_chars[0].code ||
                        last_char !== expected_chars[0].last)
                    begin
                        report_error($sformatf("char code=%02h last=%0b, expected %02h last=%0b",
                                               char_code, last_char,
                                               expected_chars[0].code,
                                               expected_chars[0].last));
                    end
                    expected_chars.pop_front();
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [VALUE_W-1:0] rnd;
        int                 bits;

        // Directed numbers: field extremes and digit-count boundaries.
        pending_numbers.push_back('{MODE_DEC, 64'd0});
        pending_numbers.push_back('{MODE_DEC, 64'd1});
        pending_numbers.push_back('{MODE_DEC, 64'd9});
        pending_numbers.push_back('{MODE_DEC, 64'd10});
        pending_numbers.push_back('{MODE_DEC, 64'd99});
        pending_numbers.push_back('{MODE_DEC, 64'd100});
        pending_numbers.push_back('{MODE_DEC, 64'd1234567890});
        pending_numbers.push_back('{MODE_DEC, 64'd9999999999999999999});
        pending_numbers.push_back('{MODE_DEC, 64'd10000000000000000000});
        pending_numbers.push_back('{MODE_DEC, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_numbers.push_back('{MODE_DEC, 64'h8000_0000_0000_0000});
        pending_numbers.push_back('{MODE_DEC, 64'hFFFF_FFFF});
        pending_numbers.push_back('{MODE_HEX, 64'h0});
        pending_numbers.push_back('{MODE_HEX, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_numbers.push_back('{MODE_HEX, 64'h0123_4567_89AB_CDEF});
        pending_numbers.push_back('{MODE_HEX, 64'hFEDC_BA98_7654_3210});
        pending_numbers.push_back('{MODE_HEX, 64'hA});
        pending_numbers.push_back('{MODE_HEX, 64'h5555_5555_5555_5555});
        pending_numbers.push_back('{MODE_HEX, 64'hAAAA_AAAA_AAAA_AAAA});
        pending_numbers.push_back('{MODE_DEC, 64'hAAAA_AAAA_AAAA_AAAA});

        // Random numbers of random bit length, so short and long texts mix.
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            rnd  = {$urandom, $urandom};
            bits = $urandom_range(1, 64);
            if (bits < 64 && $urandom_range(0, 3) != 0)
            begin
                rnd = rnd & ((64'd1 << bits) - 64'd1);
            end
            pending_numbers.push_back('{1'($urandom_range(0, 1)), rnd});
        end
        num_items = pending_numbers.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (num_accepted < num_items) @(posedge clk);
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            report_error($sformatf("%0d characters never arrived", expected_chars.size()));
        end

        if (num_errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
